>>> rtl/trs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the TCP reassembly block.
// Holds field widths, segment kind codes and the scan unit status record.
// ----------------------------------------------------------------------------
package trs_pkg;
  localparam int SEQ_W = 32;
  localparam int LEN_W = 11;
  localparam int TAG_W = 16;
  localparam int WIN_W = 5;
  localparam int DEF_STORE_ENTRIES = 16;
  localparam int DEF_MAX_SEGMENT = 1024;

  localparam logic [1:0] FUNC_DATA = 2'd0;
  localparam logic [1:0] FUNC_SYN  = 2'd1;
  localparam logic [1:0] FUNC_FIN  = 2'd2;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic done;
    logic low_found;
    logic match_found;
    logic free_found;
  } scan_stat_t;
endpackage
`default_nettype wire

>>> rtl/trs_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trs_scan: sequential scan over the segment store.
// One shared compare unit visits one entry per cycle and keeps the lowest
// valid entry, the entry matching a key, the first free entry and a count.
// ----------------------------------------------------------------------------
module trs_scan #(
  parameter int STORE_ENTRIES = trs_pkg::DEF_STORE_ENTRIES,
  parameter int IDX_W = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1,
  parameter int CNT_W = $clog2(STORE_ENTRIES + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic [trs_pkg::SEQ_W-1:0] key,
  output logic [IDX_W-1:0]              rd_idx,
  input  wire logic                     rd_valid,
  input  wire logic [trs_pkg::SEQ_W-1:0] rd_seq,
  output trs_pkg::scan_stat_t           stat,
  output logic [IDX_W-1:0]              low_idx,
  output logic [trs_pkg::SEQ_W-1:0]     low_seq,
  output logic [IDX_W-1:0]              match_idx,
  output logic [IDX_W-1:0]              free_idx,
  output logic [CNT_W-1:0]              used
);
  logic                         active;
  logic [IDX_W-1:0]             pos;
  logic                         is_last;

  assign rd_idx  = pos;
  assign is_last = (32'(pos) == STORE_ENTRIES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos <= '0;
      stat <= '0;
      used <= '0;
    end else if (go) begin
      active <= 1'b1;
      pos <= '0;
      stat <= '0;
      used <= '0;
    end else if (active) begin
      if (rd_valid) begin
        used <= used + 1'b1;
        if (!stat.low_found || rd_seq < low_seq) begin
          stat.low_found <= 1'b1;
          low_idx <= pos;
          low_seq <= rd_seq;
        end
        if (!stat.match_found && rd_seq == key) begin
          stat.match_found <= 1'b1;
          match_idx <= pos;
        end
      end else if (!stat.free_found) begin
        stat.free_found <= 1'b1;
        free_idx <= pos;
      end
      if (is_last) begin
        active <= 1'b0;
        stat.done <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) go |=> !stat.done);
  assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (32'(used) <= STORE_ENTRIES)) else $error("count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (stat.done && !stat.free_found) |-> (32'(used) == STORE_ENTRIES))
    else $error("free entry missed");
endmodule
`default_nettype wire

>>> rtl/tcp_reorder_reassembly_sack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_reorder_reassembly_sack: receive reassembly with one SACK block.
// A segment descriptor transfer happens when start is high and busy is low.
// Each result appears for one cycle with out_valid high; the receiver cannot
// hold it off. Data at the expected sequence is delivered (result_kind 0),
// then buffered entries that now line up are delivered, one per store scan.
// Later segments are stored while the store has room; older ones are only
// acknowledged. Every item that is not ignored ends with an acknowledgement
// (result_kind 1, last 1) carrying the cumulative ack, the free entries and
// the span of the lowest entry. Each store scan visits one entry per cycle
// through a single compare unit. SYN, FIN and an old segment keep busy high
// through a scan and the acknowledgement, a stored segment through a second
// scan as well, and an in-order segment through a further scan per drained
// entry. The first delivery appears in the cycle after the transfer; the
// acknowledgement appears in the cycle in which busy falls, when the next
// transfer may already be taken. Ignored items are dropped at the transfer
// and leave busy low. Reset clears the expected sequence and every valid bit
// at once.
// ----------------------------------------------------------------------------
module tcp_reorder_reassembly_sack #(
  parameter int STORE_ENTRIES = trs_pkg::DEF_STORE_ENTRIES,
  parameter int MAX_SEGMENT = trs_pkg::DEF_MAX_SEGMENT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                func,
  input  wire logic [trs_pkg::SEQ_W-1:0] seq_number,
  input  wire logic [trs_pkg::LEN_W-1:0] seg_length,
  input  wire logic [trs_pkg::TAG_W-1:0] payload_tag,
  output logic                           out_valid,
  output logic                           result_kind,
  output logic [trs_pkg::TAG_W-1:0]      out_tag,
  output logic [trs_pkg::LEN_W-1:0]      out_length,
  output logic [trs_pkg::SEQ_W-1:0]      ack_number,
  output logic [trs_pkg::WIN_W-1:0]      free_window,
  output logic [trs_pkg::SEQ_W-1:0]      sack_begin,
  output logic [trs_pkg::SEQ_W-1:0]      sack_finish,
  output logic                           last
);
  localparam int IDX_W = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(STORE_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_ACK   = 3'd4;

  logic [2:0] state;
  logic [trs_pkg::SEQ_W-1:0] next_expected;
  logic [STORE_ENTRIES-1:0]  slot_valid;
  logic [trs_pkg::SEQ_W-1:0] slot_seq [STORE_ENTRIES];
  logic [trs_pkg::LEN_W-1:0] slot_len [STORE_ENTRIES];
  logic [trs_pkg::TAG_W-1:0] slot_tag [STORE_ENTRIES];

  logic [1:0] r_func;
  logic [trs_pkg::SEQ_W-1:0] r_seq;
  logic [trs_pkg::LEN_W-1:0] r_len;
  logic [trs_pkg::TAG_W-1:0] r_tag;
  logic store_phase;

  logic scan_go;
  logic [IDX_W-1:0] scan_idx, low_idx, match_idx, free_idx;
  logic [trs_pkg::SEQ_W-1:0] low_seq;
  logic [CNT_W-1:0] used;
  trs_pkg::scan_stat_t stat;
  logic scan_valid_now;
  logic [trs_pkg::SEQ_W-1:0] scan_seq_now;

  trs_scan #(.STORE_ENTRIES(STORE_ENTRIES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_scan (
    .clk(clk), .rst(rst), .go(scan_go), .key(r_seq),
    .rd_idx(scan_idx), .rd_valid(scan_valid_now), .rd_seq(scan_seq_now),
    .stat(stat), .low_idx(low_idx), .low_seq(low_seq),
    .match_idx(match_idx), .free_idx(free_idx), .used(used)
  );
  assign scan_valid_now = slot_valid[scan_idx];
  assign scan_seq_now   = slot_seq[scan_idx];

  assign busy    = (state != ST_IDLE);
  assign scan_go = (state == ST_IDLE && start) || (state == ST_DECIDE && store_phase)
                   || (state == ST_READ);

  logic accept;
  logic take_ok;
  assign accept  = start && !busy;
  assign take_ok = (func == trs_pkg::FUNC_SYN) || (func == trs_pkg::FUNC_FIN) ||
                   (func == trs_pkg::FUNC_DATA && seg_length != '0 &&
                    32'(seg_length) <= MAX_SEGMENT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      next_expected <= '0;
      slot_valid <= '0;
      out_valid <= 1'b0;
      store_phase <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            r_func <= func; r_seq <= seq_number; r_len <= seg_length;
            r_tag <= payload_tag;
            store_phase <= 1'b0;
            if (!take_ok) begin
              state <= ST_IDLE;
            end else if (func == trs_pkg::FUNC_SYN) begin
              next_expected <= seq_number + 1'b1;
              slot_valid <= '0;
              state <= ST_SCAN;
            end else if (func == trs_pkg::FUNC_FIN) begin
              next_expected <= next_expected + 1'b1;
              slot_valid <= '0;
              state <= ST_SCAN;
            end else if (seq_number == next_expected) begin
              out_valid <= 1'b1;
              result_kind <= trs_pkg::KIND_DELIVER;
              out_tag <= payload_tag; out_length <= seg_length;
              ack_number <= '0; free_window <= '0;
              sack_begin <= '0; sack_finish <= '0; last <= 1'b0;
              next_expected <= next_expected + 32'(seg_length);
              state <= ST_SCAN;
            end else begin
              store_phase <= (seq_number > next_expected);
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (stat.done && !scan_go) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (store_phase) begin
            store_phase <= 1'b0;
            if (32'(used) < STORE_ENTRIES) begin
              if (stat.match_found) begin
                slot_len[match_idx] <= r_len; slot_tag[match_idx] <= r_tag;
              end else begin
                slot_seq[free_idx] <= r_seq; slot_len[free_idx] <= r_len;
                slot_tag[free_idx] <= r_tag; slot_valid[free_idx] <= 1'b1;
              end
            end
            state <= ST_SCAN;
          end else if (r_func == trs_pkg::FUNC_DATA && stat.low_found &&
                       low_seq == next_expected) begin
            state <= ST_READ;
          end else begin
            state <= ST_ACK;
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          result_kind <= trs_pkg::KIND_DELIVER;
          out_tag <= slot_tag[low_idx]; out_length <= slot_len[low_idx];
          ack_number <= '0; free_window <= '0;
          sack_begin <= '0; sack_finish <= '0; last <= 1'b0;
          next_expected <= next_expected + 32'(slot_len[low_idx]);
          slot_valid[low_idx] <= 1'b0;
          state <= ST_SCAN;
        end
        ST_ACK: begin
          out_valid <= 1'b1;
          result_kind <= trs_pkg::KIND_ACK;
          out_tag <= '0; out_length <= '0;
          ack_number <= next_expected;
          free_window <= trs_pkg::WIN_W'(STORE_ENTRIES - 32'(used));
          sack_begin <= stat.low_found ? low_seq : '0;
          sack_finish <= stat.low_found ? low_seq + 32'(slot_len[low_idx]) : '0;
          last <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (result_kind == trs_pkg::KIND_ACK))
    else $error("last on a delivery");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACK) |=> (out_valid && last)) else $error("ack missing");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> busy) else $error("delivery after end");
endmodule
`default_nettype wire

>>> tb/tb_tcp_reorder_reassembly_sack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_reorder_reassembly_sack: self-checking bench for TCP reassembly.
// A queue of segment descriptors feeds a clocked driver in random bursts.
// A predictor of the receive window and the reorder store builds the expected
// deliveries and acknowledgements, which a clocked monitor checks in order.
// ----------------------------------------------------------------------------
module tb_tcp_reorder_reassembly_sack;
  localparam int ENTRIES = 16;
  localparam int MAX_SEG = 1024;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]                func;
    logic [trs_pkg::SEQ_W-1:0] seq;
    logic [trs_pkg::LEN_W-1:0] len;
    logic [trs_pkg::TAG_W-1:0] tag;
    logic                      hold;
  } segment_t;

  typedef struct packed {
    logic                      kind;
    logic [trs_pkg::TAG_W-1:0] tag;
    logic [trs_pkg::LEN_W-1:0] len;
    logic [trs_pkg::SEQ_W-1:0] ack;
    logic [trs_pkg::WIN_W-1:0] win;
    logic [trs_pkg::SEQ_W-1:0] sb;
    logic [trs_pkg::SEQ_W-1:0] sf;
    logic                      last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = trs_pkg::FUNC_DATA;
  logic [trs_pkg::SEQ_W-1:0] seq_number = '0;
  logic [trs_pkg::LEN_W-1:0] seg_length = '0;
  logic [trs_pkg::TAG_W-1:0] payload_tag = '0;
  logic busy, out_valid, result_kind, last;
  logic [trs_pkg::TAG_W-1:0] out_tag;
  logic [trs_pkg::LEN_W-1:0] out_length;
  logic [trs_pkg::SEQ_W-1:0] ack_number, sack_begin, sack_finish;
  logic [trs_pkg::WIN_W-1:0] free_window;

  tcp_reorder_reassembly_sack dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .seq_number(seq_number), .seg_length(seg_length), .payload_tag(payload_tag),
    .out_valid(out_valid), .result_kind(result_kind), .out_tag(out_tag),
    .out_length(out_length), .ack_number(ack_number), .free_window(free_window),
    .sack_begin(sack_begin), .sack_finish(sack_finish), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_t pending[$];
  result_t expected_results[$];
  logic [trs_pkg::SEQ_W-1:0] rcv_next = '0;
  logic [trs_pkg::SEQ_W-1:0] store_seq[ENTRIES];
  logic [trs_pkg::LEN_W-1:0] store_len[ENTRIES];
  logic [trs_pkg::TAG_W-1:0] store_tag[ENTRIES];
  logic store_used[ENTRIES] = '{default: 1'b0};
  int errors = 0;
  int sent = 0;
  int deliveries = 0;
  int acks = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  function automatic int lowest_entry();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (store_used[i] && (best < 0 || store_seq[i] < store_seq[best])) best = i;
    return best;
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (store_used[i]) n++;
    return n;
  endfunction

  task automatic push_ack();
    result_t r;
    int lo;
    lo = lowest_entry();
    r = '0;
    r.kind = trs_pkg::KIND_ACK;
    r.ack = rcv_next;
    r.win = trs_pkg::WIN_W'(ENTRIES - used_count());
    if (lo >= 0) begin
      r.sb = store_seq[lo];
      r.sf = store_seq[lo] + trs_pkg::SEQ_W'(store_len[lo]);
    end
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  task automatic push_delivery(logic [trs_pkg::TAG_W-1:0] t,
                               logic [trs_pkg::LEN_W-1:0] l);
    result_t r;
    r = '0;
    r.kind = trs_pkg::KIND_DELIVER;
    r.tag = t;
    r.len = l;
    expected_results.push_back(r);
  endtask

  task automatic reassemble(segment_t s);
    int lo, pos;
    if (s.func == trs_pkg::FUNC_SYN || s.func == trs_pkg::FUNC_FIN) begin
      rcv_next = (s.func == trs_pkg::FUNC_SYN) ? s.seq + 1 : rcv_next + 1;
      for (int i = 0; i < ENTRIES; i++) store_used[i] = 0;
      push_ack();
      return;
    end
    if (s.func != trs_pkg::FUNC_DATA || s.len == 0 || s.len > MAX_SEG) return;
    if (s.seq == rcv_next) begin
      push_delivery(s.tag, s.len);
      rcv_next = rcv_next + trs_pkg::SEQ_W'(s.len);
      forever begin
        lo = lowest_entry();
        if (lo < 0 || store_seq[lo] != rcv_next) break;
        push_delivery(store_tag[lo], store_len[lo]);
        rcv_next = rcv_next + trs_pkg::SEQ_W'(store_len[lo]);
        store_used[lo] = 0;
      end
    end else if (s.seq > rcv_next && used_count() < ENTRIES) begin
      pos = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (pos < 0 && store_used[i] && store_seq[i] == s.seq) pos = i;
      for (int i = 0; i < ENTRIES; i++)
        if (pos < 0 && !store_used[i]) pos = i;
      store_seq[pos] = s.seq;
      store_len[pos] = s.len;
      store_tag[pos] = s.tag;
      store_used[pos] = 1;
    end
    push_ack();
  endtask

  function automatic segment_t mk(logic [1:0] f, logic [trs_pkg::SEQ_W-1:0] sq,
                                  int l, int t);
    segment_t s;
    s.func = f;
    s.seq = sq;
    s.len = trs_pkg::LEN_W'(l);
    s.tag = trs_pkg::TAG_W'(t);
    s.hold = 0;
    return s;
  endfunction

  // Stimulus: directed cases, then windows of shuffled segments after a SYN.
  initial begin
    logic [trs_pkg::SEQ_W-1:0] isn, base;
    segment_t win[$];
    segment_t s;
    int n, l, j;
    pending.push_back(mk(trs_pkg::FUNC_DATA, 0, 100, 16'hffff));
    pending.push_back(mk(trs_pkg::FUNC_SYN, 32'hffff_ffff, 0, 0));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 100, 1024, 16'h1234));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 50, 1, 1));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 0, 1, 2));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 0, 0, 3));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 1, 1025, 4));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 1, 2047, 5));
    pending.push_back(mk(2'd3, 1, 10, 6));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 100, 10, 7));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 100, 20, 8));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 130, 5, 9));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 1, 99, 16'h0));
    s = mk(trs_pkg::FUNC_FIN, 0, 0, 0);
    s.hold = 1;
    pending.push_back(s);
    pending.push_back(mk(trs_pkg::FUNC_SYN, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      pending.push_back(mk(trs_pkg::FUNC_DATA, 32'h8000_0000 + i, 1, i));
    pending.push_back(mk(trs_pkg::FUNC_DATA, 32'h8000_0000, 1, 99));
    pending.push_back(mk(trs_pkg::FUNC_FIN, 0, 0, 0));
    while (pending.size() < 440) begin
      isn = {$urandom_range(0, 3) == 0 ? 32'hffff_f000 : 32'h0} | $urandom();
      pending.push_back(mk(trs_pkg::FUNC_SYN, isn, $urandom_range(0, 2047), $urandom()));
      base = isn + 1;
      n = $urandom_range(2, 18);
      win.delete();
      for (int i = 0; i < n; i++) begin
        l = ($urandom_range(0, 7) == 0) ? MAX_SEG : $urandom_range(1, 64);
        win.push_back(mk(trs_pkg::FUNC_DATA, base, l, $urandom()));
        base = base + l;
      end
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        s = win[i]; win[i] = win[j]; win[j] = s;
      end
      foreach (win[i]) begin
        pending.push_back(win[i]);
        case ($urandom_range(0, 9))
          0: pending.push_back(win[$urandom_range(0, n - 1)]);
          1: pending.push_back(mk(2'($urandom_range(0, 3)), $urandom(),
                                  $urandom_range(0, 2047), $urandom()));
          default: ;
        endcase
      end
      if ($urandom_range(0, 1)) pending.push_back(mk(trs_pkg::FUNC_FIN, $urandom(), 0, 0));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: bursts of transfers separated by random gaps.
  int burst = 0;
  int gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        reassemble({func, seq_number, seg_length, payload_tag, 1'b0});
        sent++;
      end
      if (!(start && busy)) begin
        if (pending.size() == 0) begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end else if (pending[0].hold && expected_results.size() != 0
                     && !(start && !busy)) begin
          start <= 1'b0;
        end else if (pending[0].hold && (start && !busy)) begin
          start <= 1'b0;
        end else if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else begin
          func <= pending[0].func;
          seq_number <= pending[0].seq;
          seg_length <= pending[0].len;
          payload_tag <= pending[0].tag;
          pending[0].hold = 0;
          void'(pending.pop_front());
          start <= 1'b1;
          if (burst == 0) begin
            burst <= $urandom_range(1, 12);
            gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst <= burst - 1;
          end
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (out_valid) begin
        got = {result_kind, out_tag, out_length, ack_number, free_window,
               sack_begin, sack_finish, last};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind == trs_pkg::KIND_ACK) acks++; else deliveries++;
          if (got.kind != want.kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
          end
          if (got.tag != want.tag) begin
            $display("%0t: out_tag expected %h actual %h", $time, want.tag, got.tag);
            errors++;
          end
          if (got.len != want.len) begin
            $display("%0t: out_length expected %0d actual %0d", $time, want.len, got.len);
            errors++;
          end
          if (got.ack != want.ack) begin
            $display("%0t: ack_number expected %h actual %h", $time, want.ack, got.ack);
            errors++;
          end
          if (got.win != want.win) begin
            $display("%0t: free_window expected %0d actual %0d", $time, want.win, got.win);
            errors++;
          end
          if (got.sb != want.sb) begin
            $display("%0t: sack_begin expected %h actual %h", $time, want.sb, got.sb);
            errors++;
          end
          if (got.sf != want.sf) begin
            $display("%0t: sack_finish expected %h actual %h", $time, want.sf, got.sf);
            errors++;
          end
          if (got.last != want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG) begin
        $display("tcp_reorder_reassembly_sack test failed");
        $finish;
      end
      if (stim_done && expected_results.size() == 0) begin
        repeat (80) @(posedge clk);
        $display("Sent %0d segment transfers; checked %0d deliveries and %0d acks.",
                 sent, deliveries, acks);
        if (errors == 0 && expected_results.size() == 0)
          $display("tcp_reorder_reassembly_sack test passed");
        else
          $display("tcp_reorder_reassembly_sack test failed");
        $finish;
      end
    end
  end
endmodule

>>> filelist.f
rtl/trs_pkg.sv
rtl/trs_scan.sv
rtl/tcp_reorder_reassembly_sack.sv
tb/tb_tcp_reorder_reassembly_sack.sv
